// ===== rtl/sorted_score_table_macros.svh =====
// Assertion macros shared by the sorted score table RTL.
// Depends on a clock named clk and a reset named rst in the including scope.
`ifndef SORTED_SCORE_TABLE_MACROS_SVH
`define SORTED_SCORE_TABLE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define SST_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger at one edge implies a condition at the next edge.
`define SST_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== rtl/sst_pkg.sv =====
// Package for the sorted score table: record, item and result types, codes.
// No dependencies.
package sst_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam logic [1:0]  MODE_ADD    = 2'd0;
  localparam logic [1:0]  MODE_READ   = 2'd1;
  localparam logic [1:0]  MODE_CLEAR  = 2'd2;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  localparam logic        KIND_STATUS = 1'b0;
  localparam logic        KIND_ENTRY  = 1'b1;

  localparam logic [23:0] PAD_TAG = 24'h414141;

  typedef struct packed {
    logic [31:0] score;
    logic [23:0] tag;
  } rec_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] score;
    logic [23:0] tag;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic        dropped;
    logic        entry_valid;
    logic [5:0]  rank;
    logic [31:0] out_score;
    logic [23:0] out_tag;
    logic        last;
  } result_t;

  typedef struct packed {
    logic insert;
    logic rotate;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

// ===== rtl/sst_cell.sv =====
// One slot of the sorted record chain: holds a record, inserts or shifts.
// Depends on sst_pkg.
module sst_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic              clk,
  input  sst_pkg::cell_ctl_t ctl,
  input  logic [CNT_W-1:0]  count,
  input  sst_pkg::rec_t     new_rec,
  input  sst_pkg::rec_t     left_rec,
  input  logic              left_keep,
  input  sst_pkg::rec_t     right_rec,
  input  sst_pkg::rec_t     head_rec,
  output sst_pkg::rec_t     rec,
  output logic              keep
);

  localparam logic [CNT_W-1:0] POS      = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] POS_NEXT = CNT_W'(IDX + 1);

  sst_pkg::rec_t rec_next;

  assign keep = (POS < count) && (rec.score >= new_rec.score);

  always_comb begin
    rec_next = rec;
    if (ctl.insert) begin
      if (!keep) begin
        rec_next = left_keep ? new_rec : left_rec;
      end
    end else if (ctl.rotate) begin
      if (POS_NEXT < count) begin
        rec_next = right_rec;
      end else if (POS_NEXT == count) begin
        rec_next = head_rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

endmodule

// ===== rtl/sorted_score_table.sv =====
// Top level of the sorted score table: cell chain, sequencer, output register.
// Depends on sst_pkg, sst_cell and sorted_score_table_macros.svh.
//
//   channel  | signals                          | direction
//   item     | item_valid, item_stall, item     | in  (item_stall driven here)
//   result   | result_valid, result_stall, result | out (result_stall from sink)
//   cfg      | cfg_valid, cfg_ready, cfg_data   | in  (cfg_ready always high)
//
// Add and clear emit one status result each, unused mode none; an add inserts in
// the chain in the cycle it is accepted, every cell comparing against the new
// score in parallel. An empty readout emits only a last result, entry_valid low;
// other readouts emit a result per entry (entry count, or CAPACITY when padding),
// rotating the chain one place toward cell 0 per stored entry.
// Reset clears the count, the padding flag, the control state and result_valid only.
// item_stall is high during a readout and while a waiting result is stalled;
// a stalled result also holds the readout back.
`include "sorted_score_table_macros.svh"

module sorted_score_table #(
  parameter int CAPACITY = sst_pkg::CAPACITY_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  sst_pkg::item_t  item,
  output logic            result_valid,
  input  logic            result_stall,
  output sst_pkg::result_t result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]  count, count_next;
  logic              pad;
  sst_pkg::state_t   state, state_next;
  logic [IDX_W-1:0]  idx, idx_next;
  sst_pkg::result_t  res_next;
  logic              emit;
  logic              take;
  logic              acc;
  logic [CNT_W-1:0]  total;
  sst_pkg::cell_ctl_t ctl;
  sst_pkg::rec_t     new_rec;
  sst_pkg::rec_t     recs [CAPACITY];
  logic              keeps [CAPACITY];
  logic              rd_busy;
  logic              add_full;
  logic              rd_end;
  logic              res_held;

  assign cfg_ready  = 1'b1;
  assign take       = !result_valid || !result_stall;
  assign item_stall = (state == sst_pkg::ST_READ) || !take;
  assign acc        = item_valid && !item_stall;
  assign total      = pad ? CAP_CNT : count;
  assign new_rec    = '{score: item.score, tag: item.tag};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sst_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count),
      .new_rec   (new_rec),
      .left_rec  ((i == 0) ? new_rec : recs[(i == 0) ? 0 : i - 1]),
      .left_keep ((i == 0) ? 1'b1 : keeps[(i == 0) ? 0 : i - 1]),
      .right_rec ((i == CAPACITY - 1) ? recs[0] : recs[(i == CAPACITY - 1) ? 0 : i + 1]),
      .head_rec  (recs[0]),
      .rec       (recs[i]),
      .keep      (keeps[i])
    );
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    count_next = count;
    ctl        = '0;
    emit       = 1'b0;
    res_next   = '0;
    unique case (state)
      sst_pkg::ST_IDLE: begin
        if (acc) begin
          case (item.mode)
            sst_pkg::MODE_ADD: begin
              emit                 = 1'b1;
              res_next.kind        = sst_pkg::KIND_STATUS;
              res_next.entry_valid = 1'b1;
              res_next.last        = 1'b1;
              if (count == CAP_CNT) begin
                res_next.dropped = 1'b1;
              end else begin
                ctl.insert = 1'b1;
                count_next = count + CNT_W'(1);
              end
            end
            sst_pkg::MODE_CLEAR: begin
              emit                 = 1'b1;
              res_next.kind        = sst_pkg::KIND_STATUS;
              res_next.entry_valid = 1'b1;
              res_next.last        = 1'b1;
              count_next           = '0;
            end
            sst_pkg::MODE_READ: begin
              if (total == '0) begin
                emit          = 1'b1;
                res_next.kind = sst_pkg::KIND_ENTRY;
                res_next.last = 1'b1;
              end else begin
                state_next = sst_pkg::ST_READ;
                idx_next   = '0;
              end
            end
            default: ;
          endcase
        end
      end
      sst_pkg::ST_READ: begin
        if (take) begin
          emit                 = 1'b1;
          res_next.kind        = sst_pkg::KIND_ENTRY;
          res_next.entry_valid = 1'b1;
          res_next.rank        = 6'(idx);
          if (CNT_W'(idx) < count) begin
            res_next.out_score = recs[0].score;
            res_next.out_tag   = recs[0].tag;
            ctl.rotate         = 1'b1;
          end else begin
            res_next.out_tag = sst_pkg::PAD_TAG;
          end
          if (CNT_W'(idx) + CNT_W'(1) == total) begin
            res_next.last = 1'b1;
            state_next    = sst_pkg::ST_IDLE;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      default: state_next = sst_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sst_pkg::ST_IDLE;
      count        <= '0;
      pad          <= 1'b0;
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
      if (cfg_valid && cfg_ready) begin
        pad <= cfg_data;
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= res_next;
    end
  end

  assign rd_busy  = (state == sst_pkg::ST_READ);
  assign add_full = acc && (item.mode == sst_pkg::MODE_ADD) && (count == CAP_CNT);
  assign rd_end   = rd_busy && emit && res_next.last;
  assign res_held = result_valid && result_stall;

  `SST_ASSERT_ALWAYS(a_count_bound, count <= CAP_CNT, "entry count above capacity")
  `SST_ASSERT_ALWAYS(a_idx_bound, !rd_busy || CNT_W'(idx) < total, "readout index past end")
  `SST_ASSERT_NEXT(a_full_drop, add_full, $stable(count), "add into full table changed count")
  `SST_ASSERT_NEXT(a_last_idle, rd_end, state == sst_pkg::ST_IDLE, "readout ran past last entry")
  `SST_ASSERT_NEXT(a_no_emit_stalled, res_held, result_valid && $stable(result), "result changed")

endmodule
